// ----- rtl/core/qlfs_pkg.sv -----
// Package for the quoted line field splitter: item structs, result kinds,
// character constants and parser modes. No dependencies.
`default_nettype none

package qlfs_pkg;

    localparam int unsigned LIMIT_W = 6;
    localparam int unsigned CAP_W   = 16;

    localparam logic [LIMIT_W-1:0] FIELD_LIMIT_RST     = 6'd16;
    localparam logic [CAP_W-1:0]   BUFFER_CAPACITY_RST = 16'd1024;

    // configuration register indexes
    localparam logic CFG_FIELD_LIMIT     = 1'b0;
    localparam logic CFG_BUFFER_CAPACITY = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_SEP  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_BSLASH = 8'd92;

    typedef enum logic [5:0] {
        MODE_SKIP    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_MAIN    = 6'b000100,
        MODE_BLANK   = 6'b001000,
        MODE_QUOTE   = 6'b010000,
        MODE_ESCAPE  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [7:0]         out_byte;
        logic [LIMIT_W-1:0] field_index;
        logic [LIMIT_W-1:0] field_count;
        logic               overflowed;
    } out_item_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/quoted_line_field_splitter.sv -----
// Quoted line field splitter top level: input register, parser state and
// result register. Depends on qlfs_pkg.
`default_nettype none

// Takes one byte (or an end-of-input mark) per item and cuts the stream into
// lines and fields, giving at most one result per item: a stored data byte,
// a field separator, or a line-finished item with the field count and the
// overflow flag. One item is accepted every cycle while m_ready does not
// stall the output; each item sits in the input register and its result in
// the result register, and the parser state updates once per item as it
// leaves the input register. Backpressure on m_ready stalls the input
// register and then s_ready. Configuration writes take effect at once for
// field_limit and at the next line start for buffer_capacity; write them
// only while the block is idle.
module quoted_line_field_splitter
    import qlfs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_index,
    input  wire logic [CAP_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0] field_limit_reg;
    logic [CAP_W-1:0]   buffer_capacity_reg;

    logic               in_valid_reg;
    in_item_t           in_item_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    mode_t              mode_reg, mode_next;
    logic               quote_dbl_reg, quote_dbl_next;
    logic [LIMIT_W-1:0] cur_field_reg, cur_field_next;
    logic [LIMIT_W-1:0] fields_seen_reg, fields_seen_next;
    logic [CAP_W-1:0]   space_left_reg, space_left_next;
    logic               dropped_reg, dropped_next;

    logic               advance;
    logic               emit;
    out_item_t          res;
    logic               do_main, do_store, do_finish;
    logic [7:0]         store_byte;
    logic [7:0]         c;
    logic               eof;
    logic [7:0]         quote_ch;
    logic [LIMIT_W-1:0] slot;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    assign c        = in_item_reg.in_byte;
    assign eof      = in_item_reg.end_of_input;
    assign quote_ch = quote_dbl_reg ? CH_DQUOTE : CH_SQUOTE;
    assign slot     = (cur_field_reg != '0) ? cur_field_reg - 1'b1 : '0;

    always_comb begin
        mode_next        = mode_reg;
        quote_dbl_next   = quote_dbl_reg;
        cur_field_next   = cur_field_reg;
        fields_seen_next = fields_seen_reg;
        space_left_next  = space_left_reg;
        dropped_next     = dropped_reg;
        emit             = 1'b0;
        res              = '0;
        do_main          = 1'b0;
        do_store         = 1'b0;
        do_finish        = 1'b0;
        store_byte       = c;

        case (mode_reg)
            MODE_COMMENT: begin
                if (eof) begin
                    do_finish = 1'b1;
                end else if (c == CH_LF) begin
                    mode_next = MODE_SKIP;
                end
            end
            MODE_MAIN, MODE_BLANK: begin
                if (eof) begin
                    do_finish = 1'b1;
                end else begin
                    do_main = 1'b1;
                end
            end
            MODE_QUOTE: begin
                if (eof || (c == CH_LF)) begin
                    fields_seen_next = cur_field_reg;
                    do_finish        = 1'b1;
                end else if (c == quote_ch) begin
                    fields_seen_next = cur_field_reg;
                    mode_next        = MODE_MAIN;
                end else if (c == CH_BSLASH) begin
                    mode_next = MODE_ESCAPE;
                end else begin
                    do_store = 1'b1;
                end
            end
            MODE_ESCAPE: begin
                if (eof) begin
                    fields_seen_next = cur_field_reg;
                    do_finish        = 1'b1;
                end else begin
                    mode_next = MODE_QUOTE;
                    do_store  = 1'b1;
                end
            end
            default: begin
                // line start; also recovers from a mode with no meaning
                mode_next = MODE_SKIP;
                if (eof) begin
                    do_finish = 1'b1;
                end else if (c == CH_HASH) begin
                    mode_next = MODE_COMMENT;
                end else if (!is_space(c)) begin
                    mode_next = MODE_MAIN;
                    do_main   = 1'b1;
                end
            end
        endcase

        if (do_main) begin
            if (c == CH_LF) begin
                do_finish = 1'b1;
            end else if (is_blank(c)) begin
                if (mode_reg != MODE_BLANK) begin
                    mode_next = MODE_BLANK;
                    if (cur_field_reg < field_limit_reg) begin
                        if (space_left_reg == '0) begin
                            dropped_next = 1'b1;
                        end else begin
                            space_left_next = space_left_reg - 1'b1;
                            cur_field_next  = cur_field_reg + 1'b1;
                            emit            = 1'b1;
                            res.out_kind    = KIND_SEP;
                            res.field_index = cur_field_reg;
                        end
                    end else begin
                        // past the limit a blank run becomes one stored space
                        store_byte = CH_SPACE;
                        do_store   = 1'b1;
                    end
                end
            end else begin
                mode_next = MODE_MAIN;
                if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                    quote_dbl_next = (c == CH_DQUOTE);
                    mode_next      = MODE_QUOTE;
                end else begin
                    fields_seen_next = cur_field_reg;
                    do_store         = 1'b1;
                end
            end
        end

        if (do_store) begin
            if (space_left_reg == '0) begin
                dropped_next = 1'b1;
            end else begin
                space_left_next = space_left_reg - 1'b1;
                emit            = 1'b1;
                res.out_kind    = KIND_DATA;
                res.out_byte    = store_byte;
                res.field_index = slot;
            end
        end

        if (do_finish) begin
            emit             = 1'b1;
            res              = '0;
            res.out_kind     = KIND_END;
            res.field_count  = fields_seen_next;
            res.overflowed   = dropped_reg;
            mode_next        = MODE_SKIP;
            quote_dbl_next   = 1'b0;
            cur_field_next   = (field_limit_reg != '0) ? LIMIT_W'(1) : '0;
            fields_seen_next = '0;
            space_left_next  = buffer_capacity_reg;
            dropped_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_limit_reg     <= FIELD_LIMIT_RST;
            buffer_capacity_reg <= BUFFER_CAPACITY_RST;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            mode_reg            <= MODE_SKIP;
            quote_dbl_reg       <= 1'b0;
            cur_field_reg       <= LIMIT_W'(1);
            fields_seen_reg     <= '0;
            space_left_reg      <= BUFFER_CAPACITY_RST;
            dropped_reg         <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIELD_LIMIT:     field_limit_reg     <= cfg_data[LIMIT_W-1:0];
                    CFG_BUFFER_CAPACITY: buffer_capacity_reg <= cfg_data;
                    default:             field_limit_reg     <= field_limit_reg;
                endcase
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg   <= emit;
                mode_reg        <= mode_next;
                quote_dbl_reg   <= quote_dbl_next;
                cur_field_reg   <= cur_field_next;
                fields_seen_reg <= fields_seen_next;
                space_left_reg  <= space_left_next;
                dropped_reg     <= dropped_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance && emit) begin
            out_item_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qlfs_checker.sv -----
// Port-level checks for quoted_line_field_splitter and the bind that attaches
// them. Depends on qlfs_pkg.
`default_nettype none

module qlfs_checker
    import qlfs_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_kind == KIND_DATA || m_data.out_kind == KIND_SEP ||
                     m_data.out_kind == KIND_END))
        else $error("unknown result kind");

    a_sep_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == KIND_SEP |->
            m_data.out_byte == '0 && m_data.field_count == '0 && !m_data.overflowed)
        else $error("separator carries stray fields");

    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == KIND_END |->
            m_data.out_byte == '0 && m_data.field_index == '0)
        else $error("line end carries stray fields");

endmodule

bind quoted_line_field_splitter qlfs_checker u_qlfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- tb/quoted_line_field_splitter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for quoted_line_field_splitter: directed and random text goes in
// through the byte channel, and a parser inside the bench predicts every result item.
// Depends on qlfs_pkg and the quoted_line_field_splitter RTL.
module quoted_line_field_splitter_tb;
    import qlfs_pkg::*;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_FIELD_LIMIT;
    logic [CAP_W-1:0] cfg_data  = '0;

    quoted_line_field_splitter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bench copy of the parser state and registers
    mode_t              ps_mode;
    logic               ps_dquote;
    logic [LIMIT_W-1:0] ps_field;
    logic [LIMIT_W-1:0] ps_count;
    logic [CAP_W-1:0]   ps_room;
    logic               ps_lost;
    logic [LIMIT_W-1:0] ps_limit;
    logic [CAP_W-1:0]   ps_cap;

    in_item_t  byte_queue[$];
    out_item_t awaited_tokens[$];
    out_item_t token_got;
    out_item_t token_want;

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    logic cfg_fire = 1'b0;

    int queued       = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int lines_seen   = 0;
    int writes_done  = 0;
    int errors       = 0;

    int   send_gap  = 0;
    logic send_calm = 1'b0;
    int   recv_gap  = 0;
    logic recv_calm = 1'b0;
    logic held_once = 1'b0;

    function automatic void begin_line();
        ps_mode   = MODE_SKIP;
        ps_dquote = 1'b0;
        ps_field  = (ps_limit != 0) ? 6'd1 : 6'd0;
        ps_count  = '0;
        ps_room   = ps_cap;
        ps_lost   = 1'b0;
    endfunction

    function automatic bit keep_byte(input logic [7:0] c, output out_item_t r);
        r = '0;
        if (ps_room == 0) begin
            ps_lost = 1'b1;
            return 0;
        end
        ps_room--;
        r.out_kind    = KIND_DATA;
        r.out_byte    = c;
        r.field_index = (ps_field != 0) ? ps_field - 6'd1 : 6'd0;
        return 1;
    endfunction

    function automatic bit close_line(output out_item_t r);
        r = '0;
        r.out_kind    = KIND_END;
        r.field_count = ps_count;
        r.overflowed  = ps_lost;
        begin_line();
        return 1;
    endfunction

    // byte inside a field or a blank run
    function automatic bit field_byte(input logic [7:0] c, output out_item_t r);
        r = '0;
        if (c == CH_LF)
            return close_line(r);
        if (c == CH_SPACE || c == CH_TAB) begin
            if (ps_mode == MODE_BLANK)
                return 0;
            ps_mode = MODE_BLANK;
            if (ps_field < ps_limit) begin
                if (ps_room == 0) begin
                    ps_lost = 1'b1;
                    return 0;
                end
                ps_room--;
                r.out_kind    = KIND_SEP;
                r.field_index = ps_field;
                ps_field++;
                return 1;
            end
            // past the limit a blank run becomes one stored space
            return keep_byte(CH_SPACE, r);
        end
        ps_mode = MODE_MAIN;
        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            ps_dquote = (c == CH_DQUOTE);
            ps_mode   = MODE_QUOTE;
            return 0;
        end
        ps_count = ps_field;
        return keep_byte(c, r);
    endfunction

    function automatic bit parse_byte(input in_item_t it, output out_item_t r);
        logic [7:0] c;
        logic       eoi;
        logic [7:0] q;
        c   = it.in_byte;
        eoi = it.end_of_input;
        r   = '0;
        case (ps_mode)
            MODE_COMMENT: begin
                if (eoi)
                    return close_line(r);
                if (c == CH_LF)
                    ps_mode = MODE_SKIP;
                return 0;
            end
            MODE_MAIN, MODE_BLANK: begin
                if (eoi)
                    return close_line(r);
                return field_byte(c, r);
            end
            MODE_QUOTE: begin
                if (eoi) begin
                    ps_count = ps_field;
                    return close_line(r);
                end
                q = ps_dquote ? CH_DQUOTE : CH_SQUOTE;
                if (c == q) begin
                    ps_count = ps_field;
                    ps_mode  = MODE_MAIN;
                    return 0;
                end
                if (c == CH_LF) begin
                    ps_count = ps_field;
                    return close_line(r);
                end
                if (c == CH_BSLASH) begin
                    ps_mode = MODE_ESCAPE;
                    return 0;
                end
                return keep_byte(c, r);
            end
            MODE_ESCAPE: begin
                if (eoi) begin
                    ps_count = ps_field;
                    return close_line(r);
                end
                ps_mode = MODE_QUOTE;
                return keep_byte(c, r);
            end
            default: begin
                ps_mode = MODE_SKIP;
                if (eoi)
                    return close_line(r);
                if (c == CH_HASH) begin
                    ps_mode = MODE_COMMENT;
                    return 0;
                end
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    return 0;
                ps_mode = MODE_MAIN;
                return field_byte(c, r);
            end
        endcase
        return 0;
    endfunction

    // sample every handshake at the rising edge and keep the prediction in step
    always @(posedge aclk) begin
        in_fire  <= aresetn && s_valid && s_ready;
        out_fire <= aresetn && m_valid && m_ready;
        cfg_fire <= aresetn && cfg_valid && cfg_ready;
        if (!aresetn) begin
            ps_limit = FIELD_LIMIT_RST;
            ps_cap   = BUFFER_CAPACITY_RST;
            begin_line();
        end else begin
            if (cfg_valid && cfg_ready) begin
                writes_done++;
                if (cfg_index == CFG_FIELD_LIMIT)
                    ps_limit = cfg_data[LIMIT_W-1:0];
                else
                    ps_cap = cfg_data;
            end
            if (s_valid && s_ready) begin
                items_taken++;
                if (parse_byte(s_data, token_got))
                    awaited_tokens.push_back(token_got);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_tokens.size() == 0) begin
                    $error("result item with none awaited: out_kind %0d out_byte %0d",
                           m_data.out_kind, m_data.out_byte);
                    errors++;
                end else begin
                    token_want = awaited_tokens.pop_front();
                    if (token_want.out_kind == KIND_END)
                        lines_seen++;
                    if (m_data.out_kind !== token_want.out_kind) begin
                        $error("out_kind: expected %0d, actual %0d",
                               token_want.out_kind, m_data.out_kind);
                        errors++;
                    end
                    if (m_data.out_byte !== token_want.out_byte) begin
                        $error("out_byte: expected %0d, actual %0d",
                               token_want.out_byte, m_data.out_byte);
                        errors++;
                    end
                    if (m_data.field_index !== token_want.field_index) begin
                        $error("field_index: expected %0d, actual %0d",
                               token_want.field_index, m_data.field_index);
                        errors++;
                    end
                    if (m_data.field_count !== token_want.field_count) begin
                        $error("field_count: expected %0d, actual %0d",
                               token_want.field_count, m_data.field_count);
                        errors++;
                    end
                    if (m_data.overflowed !== token_want.overflowed) begin
                        $error("overflowed: expected %0d, actual %0d",
                               token_want.overflowed, m_data.overflowed);
                        errors++;
                    end
                end
            end
        end
    end

    // byte driver: random gap before each item, with calm stretches of no gap
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_fire)) begin
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (byte_queue.size() != 0) begin
                s_data   <= byte_queue.pop_front();
                s_valid  <= 1'b1;
                send_gap <= send_calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0)
                    send_calm <= !send_calm;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall per item, plus one long hold to back up the input
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_fire) begin
                recv_gap = recv_calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0)
                    recv_calm = !recv_calm;
                if (!held_once && results_seen >= 200 && byte_queue.size() > 20) begin
                    recv_gap  = 120;
                    held_once = 1'b1;
                end
            end
            if (recv_gap > 0) begin
                m_ready  <= 1'b0;
                recv_gap = recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic put_item(input logic [7:0] c, input logic eoi);
        byte_queue.push_back(in_item_t'{in_byte: c, end_of_input: eoi});
        queued++;
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_item(s[i], 1'b0);
    endtask

    task automatic put_eof();
        put_item(8'($urandom), 1'b1);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 255));
        while (c == CH_DQUOTE || c == CH_SQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    // wait for the input queue and all awaited items to drain, then for the pipeline
    task automatic settle();
        while (byte_queue.size() != 0 || s_valid || awaited_tokens.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CAP_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge aclk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits are random; only the low bits reach the limit register
    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        logic [CAP_W-1:0] v;
        v = CAP_W'($urandom);
        v[LIMIT_W-1:0] = lim;
        write_reg(CFG_FIELD_LIMIT, v);
    endtask

    // mostly well-formed lines with random content, some noise bursts
    task automatic fill(input int n);
        int         stop;
        int         nf;
        int         k;
        logic [7:0] q;
        stop = queued + n;
        while (queued < stop) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6))
                    put_item(8'($urandom), $urandom_range(0, 15) == 0);
            end else begin
                repeat ($urandom_range(0, 2))
                    put_item(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13))
                                                        : CH_SPACE, 1'b0);
                case ($urandom_range(0, 11))
                    0: begin
                        put_item(CH_HASH, 1'b0);
                        repeat ($urandom_range(0, 5))
                            put_item(word_char(), 1'b0);
                        put_item(CH_LF, 1'b0);
                    end
                    1: put_item(CH_LF, 1'b0);
                    default: begin
                        nf = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                                           : $urandom_range(1, 8);
                        for (k = 0; k < nf; k++) begin
                            if (k != 0)
                                repeat ($urandom_range(1, 3))
                                    put_item(blank_char(), 1'b0);
                            if ($urandom_range(0, 3) == 0) begin
                                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                                put_item(q, 1'b0);
                                repeat ($urandom_range(0, 6)) begin
                                    case ($urandom_range(0, 5))
                                        0: begin
                                            put_item(CH_BSLASH, 1'b0);
                                            put_item(8'($urandom), 1'b0);
                                        end
                                        1: put_item(blank_char(), 1'b0);
                                        default: put_item(word_char(), 1'b0);
                                    endcase
                                end
                                // now and then the quote is left open
                                if ($urandom_range(0, 9) != 0)
                                    put_item(q, 1'b0);
                            end else begin
                                repeat ($urandom_range(1, 5))
                                    put_item(word_char(), 1'b0);
                            end
                        end
                        if ($urandom_range(0, 5) == 0)
                            put_item(blank_char(), 1'b0);
                        if ($urandom_range(0, 11) == 0)
                            put_eof();
                        else
                            put_item(CH_LF, 1'b0);
                    end
                endcase
            end
        end
    endtask

    task automatic phase(input logic [LIMIT_W-1:0] lim, input logic [CAP_W-1:0] cap,
                         input int n);
        settle();
        write_limit(lim);
        write_reg(CFG_BUFFER_CAPACITY, cap);
        fill(n);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        put_text(" #\n");
        put_item(8'h00, 1'b0);
        put_item(8'hFF, 1'b0);
        put_text("\t\"\\\"\\\n \"'r'\n");  // quoted blank, escaped quote, escaped newline
        put_text("\"a\n'b");
        put_eof();
        put_text("\"\\");
        put_eof();
        put_eof();
        put_text("a b");
        settle();
        write_limit(6'd1);  // lowered with the line still open
        put_text(" c\n");
        settle();
        write_limit(6'd0);
        write_reg(CFG_BUFFER_CAPACITY, 16'd3);
        put_text("x\nab\tc\n");  // first line still sees the old line state

        phase(6'd16, 16'd1024, 45);
        settle();  // sender holds until every awaited item is back
        fill(45);
        phase(6'd63, 16'hFFFF, 120);
        phase(6'd3, 16'd40, 100);
        phase(6'd0, 16'd25, 80);
        phase(6'd2, 16'd0, 60);
        phase(6'd5, 16'd12, 100);
        phase(6'd63, 16'd300, 100);
        phase(6'd1, 16'hFFFF, 100);
        settle();

        $display("run took %0d bytes, checked %0d result items over %0d finished lines",
                 items_taken, results_seen, lines_seen);
        $display("%0d register writes, field limits 0 to 63, capacities 0 to 65535",
                 writes_done);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("run timed out with %0d result items still awaited", awaited_tokens.size());
        $display("status: fail");
        $finish;
    end

endmodule
